### design/pfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_CPUS  = 8;
  localparam int NUM_PAGES = 1024;
  localparam int REF_BITS  = 8;

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int LINK_W = PAGE_W + 1;
  localparam int LEN_W  = $clog2(2 * NUM_PAGES);
  localparam int CFG_W  = 10;

  localparam int IN_W  = 3 + CPU_W + PAGE_W;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = PAGE_W + 3 + REF_BITS + LEN_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(2 * NUM_PAGES - 1);

  typedef enum logic [2:0] {
    ACT_ALLOC      = 3'd0,
    ACT_FREE       = 3'd1,
    ACT_INC_REF    = 3'd2,
    ACT_DEC_REF    = 3'd3,
    ACT_GET_REF    = 3'd4,
    ACT_INIT       = 3'd5,
    ACT_FREE_TOTAL = 3'd6,
    ACT_UNUSED     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_OOM       = 3'd1,
    STS_BAD_PAGE  = 3'd2,
    STS_STILL_REF = 3'd3,
    STS_NEG_RESET = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_RST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT_CLEAR,
    ST_REF_UPD,
    ST_POP_FIN,
    ST_STEAL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_CLEAR_PUSH,
    OP_REF_READ,
    OP_REF_UPDATE,
    OP_POP_READ,
    OP_POP_FINISH,
    OP_STEAL_START,
    OP_STEAL_STEP,
    OP_STEAL_FINISH,
    OP_OOM,
    OP_SUM_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } pfa_cmd_t;

  typedef struct packed {
    action_t act;
    logic    head_empty;
    logic    steal_avail;
    logic    steal_more;
    logic    sweep_last;
    logic    sum_last;
    logic    out_free;
  } pfa_sts_t;

endpackage
`default_nettype wire

### design/pfa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/pfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: steps the datapath through each operation.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pfa_pkg::pfa_sts_t sts,
  output pfa_pkg::pfa_cmd_t      cmd
);
  import pfa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RST_CLEAR: if (sts.sweep_last) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (sts.act)
          ACT_ALLOC: begin
            if (!sts.head_empty) state_next = ST_POP_FIN;
            else if (sts.steal_avail) state_next = ST_STEAL;
            else state_next = ST_DONE;
          end
          ACT_FREE, ACT_INC_REF, ACT_DEC_REF, ACT_GET_REF: state_next = ST_REF_UPD;
          ACT_INIT:       state_next = ST_INIT_CLEAR;
          ACT_FREE_TOTAL: state_next = ST_SUM;
          default:        state_next = ST_DONE;
        endcase
      end
      ST_INIT_CLEAR: if (sts.sweep_last) state_next = ST_DONE;
      ST_REF_UPD:    state_next = ST_DONE;
      ST_POP_FIN:    state_next = ST_DONE;
      ST_STEAL:      if (!sts.steal_more) state_next = ST_DONE;
      ST_SUM:        if (sts.sum_last) state_next = ST_DONE;
      ST_DONE:       if (sts.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    case (state)
      ST_RST_CLEAR: cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DISPATCH: begin
        case (sts.act)
          ACT_ALLOC: begin
            if (!sts.head_empty) cmd.op = OP_POP_READ;
            else if (sts.steal_avail) cmd.op = OP_STEAL_START;
            else cmd.op = OP_OOM;
          end
          ACT_FREE, ACT_INC_REF, ACT_DEC_REF, ACT_GET_REF: cmd.op = OP_REF_READ;
          default: cmd.op = OP_NONE;
        endcase
      end
      ST_INIT_CLEAR: cmd.op = OP_CLEAR_PUSH;
      ST_REF_UPD:    cmd.op = OP_REF_UPDATE;
      ST_POP_FIN:    cmd.op = OP_POP_FINISH;
      ST_STEAL:      cmd.op = sts.steal_more ? OP_STEAL_STEP : OP_STEAL_FINISH;
      ST_SUM:        cmd.op = OP_SUM_STEP;
      ST_DONE:       if (sts.out_free) cmd.op = OP_EMIT;
      default:       cmd.op = OP_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_after_reset: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("input taken right after reset");
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> sts.out_free)
    else $error("result emitted over a pending result");
  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && sts.out_free) |=> (state == ST_IDLE))
    else $error("finished result not moved to output");
`endif

endmodule
`default_nettype wire

### design/pfa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: list heads and lengths, link and count RAMs, result registers.
// ----------------------------------------------------------------------------
module pfa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pfa_pkg::IN_TW-1:0]     s_tdata,
  output logic      [pfa_pkg::OUT_TW-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          cfg_we,
  input  wire logic [pfa_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire pfa_pkg::pfa_cmd_t             cmd,
  output pfa_pkg::pfa_sts_t                  sts
);
  import pfa_pkg::*;

  localparam logic signed [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
  localparam logic signed [REF_BITS-1:0] REF_MAXV = {1'b0, {(REF_BITS-1){1'b1}}};
  localparam logic signed [REF_BITS-1:0] REF_MINV = {1'b1, {(REF_BITS-1){1'b0}}};

  // captured transaction
  action_t           act_q;
  logic [CPU_W-1:0]  cpu_q;
  logic [PAGE_W-1:0] page_q;
  logic [CFG_W-1:0]  ffp;

  logic [LINK_W-1:0] head [NUM_CPUS];
  logic [LEN_W-1:0]  len  [NUM_CPUS];

  logic [PAGE_W-1:0] ctr;
  logic [CPU_W-1:0]  sum_idx;

  // steal walk
  logic [CPU_W-1:0]  vi;
  logic [LINK_W-1:0] r_pg, p_pg, rlink;
  logic [LEN_W-1:0]  taken, want;

  // result
  logic [PAGE_W-1:0]          res_granted;
  status_t                    res_status;
  logic signed [REF_BITS-1:0] res_ref;
  logic [LEN_W-1:0]           res_free;

  logic [PAGE_W-1:0]          out_granted;
  status_t                    out_status;
  logic [REF_BITS-1:0]        out_ref;
  logic [LEN_W-1:0]           out_free_pages;

  // RAM ports
  logic                       link_we;
  logic [PAGE_W-1:0]          link_waddr, link_raddr;
  logic [LINK_W-1:0]          link_wdata, link_rdata;
  logic                       ref_we;
  logic [PAGE_W-1:0]          ref_waddr;
  logic [REF_BITS-1:0]        ref_wdata, ref_rdata;

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  pfa_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_PAGES)) u_ref_ram (
    .clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
    .raddr(page_q), .rdata(ref_rdata)
  );

  // victim search: first other CPU with a non-empty list
  logic [CPU_W-1:0] vi_sel;
  logic             vi_found;
  always_comb begin
    vi_sel   = '0;
    vi_found = 1'b0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (!vi_found && CPU_W'(i) != cpu_q && head[i] != NULL_LINK) begin
        vi_sel   = CPU_W'(i);
        vi_found = 1'b1;
      end
    end
  end

  logic [LEN_W-1:0] want_sel;
  always_comb begin
    want_sel = len[vi_sel] >> 1;
    if (want_sel == '0) want_sel = LEN_W'(1);
  end

  logic [LINK_W-1:0] nx;
  assign nx = link_rdata;

  logic steal_more;
  assign steal_more = (taken < want) && (nx != NULL_LINK);

  // reference count update
  logic                       in_range, bad;
  logic signed [REF_BITS-1:0] ref_old, upd_data, upd_ref;
  logic                       upd_we, upd_push;
  status_t                    upd_status;

  assign in_range = 32'(page_q) < NUM_PAGES;
  assign bad      = !in_range || (act_q == ACT_FREE && 32'(page_q) < 32'(ffp));
  assign ref_old  = ref_rdata;

  always_comb begin
    upd_we     = 1'b0;
    upd_push   = 1'b0;
    upd_data   = ref_old;
    upd_ref    = '0;
    upd_status = STS_OK;
    if (bad) begin
      upd_status = STS_BAD_PAGE;
    end else begin
      case (act_q)
        ACT_FREE: begin
          upd_we = 1'b1;
          if (ref_old > REF_ONE) begin
            upd_data   = ref_old - REF_ONE;
            upd_ref    = ref_old - REF_ONE;
            upd_status = STS_STILL_REF;
          end else begin
            upd_data   = '0;
            upd_push   = 1'b1;
            upd_status = ref_old[REF_BITS-1] ? STS_NEG_RESET : STS_OK;
          end
        end
        ACT_INC_REF: begin
          upd_we   = 1'b1;
          upd_data = (ref_old != REF_MAXV) ? ref_old + REF_ONE : ref_old;
          upd_ref  = upd_data;
        end
        ACT_DEC_REF: begin
          upd_ref = ref_old;
          if (ref_old != REF_MINV) begin
            upd_we   = 1'b1;
            upd_data = ref_old - REF_ONE;
            upd_ref  = ref_old - REF_ONE;
            upd_push = (ref_old == REF_ONE);
          end
        end
        ACT_GET_REF: upd_ref = ref_old;
        default: upd_ref = '0;
      endcase
    end
  end

  // push onto the caller's list
  logic              clr_first, do_push;
  logic [PAGE_W-1:0] push_pg;
  logic [LINK_W-1:0] base_head;
  logic [LEN_W-1:0]  base_len, push_len;

  assign clr_first = (cmd.op == OP_CLEAR_PUSH) && (ctr == '0);
  assign push_pg   = (cmd.op == OP_CLEAR_PUSH) ? ctr : page_q;
  assign base_head = clr_first ? NULL_LINK : head[cpu_q];
  assign base_len  = clr_first ? '0 : len[cpu_q];
  assign push_len  = (base_len == LEN_MAX) ? base_len : base_len + LEN_W'(1);
  assign do_push   = ((cmd.op == OP_CLEAR_PUSH) && (32'(ctr) >= 32'(ffp))) ||
                     ((cmd.op == OP_REF_UPDATE) && upd_push);

  // RAM write and read muxing
  always_comb begin
    link_we    = 1'b0;
    link_waddr = push_pg;
    link_wdata = base_head;
    if (do_push) begin
      link_we = 1'b1;
    end else if (cmd.op == OP_STEAL_FINISH) begin
      link_we    = 1'b1;
      link_waddr = p_pg[PAGE_W-1:0];
      link_wdata = NULL_LINK;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_POP_READ:    link_raddr = head[cpu_q][PAGE_W-1:0];
      OP_STEAL_START: link_raddr = head[vi_sel][PAGE_W-1:0];
      OP_STEAL_STEP:  link_raddr = nx[PAGE_W-1:0];
      default:        link_raddr = '0;
    endcase
  end

  always_comb begin
    ref_we    = 1'b0;
    ref_waddr = ctr;
    ref_wdata = '0;
    case (cmd.op)
      OP_CLEAR, OP_CLEAR_PUSH: ref_we = 1'b1;
      OP_REF_UPDATE: begin
        ref_we    = upd_we;
        ref_waddr = page_q;
        ref_wdata = upd_data;
      end
      OP_POP_FINISH: begin
        ref_we    = 1'b1;
        ref_waddr = head[cpu_q][PAGE_W-1:0];
        ref_wdata = REF_ONE;
      end
      OP_STEAL_FINISH: begin
        ref_we    = 1'b1;
        ref_waddr = r_pg[PAGE_W-1:0];
        ref_wdata = REF_ONE;
      end
      default: ref_we = 1'b0;
    endcase
  end

  // list heads and lengths
  logic [LINK_W-1:0] rlink_eff;
  assign rlink_eff = (taken == LEN_W'(1)) ? nx : rlink;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head[i] <= NULL_LINK;
        len[i]  <= '0;
      end
    end else begin
      case (cmd.op)
        OP_CLEAR_PUSH: begin
          if (clr_first) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
              head[i] <= NULL_LINK;
              len[i]  <= '0;
            end
          end
          if (do_push) begin
            head[cpu_q] <= {1'b0, ctr};
            len[cpu_q]  <= push_len;
          end
        end
        OP_REF_UPDATE: begin
          if (do_push) begin
            head[cpu_q] <= {1'b0, page_q};
            len[cpu_q]  <= push_len;
          end
        end
        OP_POP_FINISH: begin
          head[cpu_q] <= nx;
          if (nx == NULL_LINK || len[cpu_q] == '0) len[cpu_q] <= '0;
          else len[cpu_q] <= len[cpu_q] - LEN_W'(1);
        end
        OP_STEAL_FINISH: begin
          head[vi] <= nx;
          if (nx == NULL_LINK || len[vi] <= taken) len[vi] <= '0;
          else len[vi] <= len[vi] - taken;
          head[cpu_q] <= (p_pg == r_pg) ? NULL_LINK : rlink_eff;
          len[cpu_q]  <= taken - LEN_W'(1);
        end
        default: ;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr     <= '0;
      sum_idx <= '0;
      ffp     <= '0;
    end else begin
      if (cfg_we) ffp <= cfg_wdata;
      if (cmd.op == OP_CLEAR || cmd.op == OP_CLEAR_PUSH) begin
        ctr <= (ctr == PAGE_W'(NUM_PAGES - 1)) ? '0 : ctr + PAGE_W'(1);
      end
      if (cmd.op == OP_SUM_STEP) begin
        sum_idx <= (sum_idx == CPU_W'(NUM_CPUS - 1)) ? '0 : sum_idx + CPU_W'(1);
      end
    end
  end

  // transaction capture, steal walk and result
  logic [LEN_W:0] sum_wide;
  assign sum_wide = {1'b0, res_free} + {1'b0, len[sum_idx]};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_q       <= action_t'(s_tdata[2:0]);
        cpu_q       <= s_tdata[3 +: CPU_W];
        page_q      <= s_tdata[3 + CPU_W +: PAGE_W];
        res_granted <= '0;
        res_status  <= STS_OK;
        res_ref     <= '0;
        res_free    <= '0;
      end
      OP_REF_UPDATE: begin
        res_status <= upd_status;
        res_ref    <= upd_ref;
      end
      OP_POP_FINISH: begin
        res_granted <= head[cpu_q][PAGE_W-1:0];
        res_ref     <= REF_ONE;
      end
      OP_STEAL_START: begin
        vi    <= vi_sel;
        r_pg  <= head[vi_sel];
        p_pg  <= head[vi_sel];
        taken <= LEN_W'(1);
        want  <= want_sel;
      end
      OP_STEAL_STEP: begin
        if (taken == LEN_W'(1)) rlink <= nx;
        p_pg  <= nx;
        taken <= taken + LEN_W'(1);
      end
      OP_STEAL_FINISH: begin
        res_granted <= r_pg[PAGE_W-1:0];
        res_ref     <= REF_ONE;
      end
      OP_OOM: res_status <= STS_OOM;
      OP_SUM_STEP: begin
        res_free <= sum_wide[LEN_W] ? LEN_MAX : sum_wide[LEN_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_granted    <= res_granted;
      out_status     <= res_status;
      out_ref        <= res_ref;
      out_free_pages <= res_free;
    end
  end

  assign m_tdata = OUT_TW'({out_free_pages, out_ref, out_status, out_granted});

  assign sts.act         = act_q;
  assign sts.head_empty  = (head[cpu_q] == NULL_LINK);
  assign sts.steal_avail = vi_found;
  assign sts.steal_more  = steal_more;
  assign sts.sweep_last  = (ctr == PAGE_W'(NUM_PAGES - 1));
  assign sts.sum_last    = (sum_idx == CPU_W'(NUM_CPUS - 1));
  assign sts.out_free    = !m_tvalid || m_tready;

endmodule
`default_nettype wire

### design/page_frame_allocator_refcount.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Per-CPU LIFO free-list page allocator with signed saturating ref counts.
// ----------------------------------------------------------------------------
// One transaction in, one result out. After reset the block sweeps the
// reference count RAM to zero over all NUM_PAGES (1024) pages and holds
// s_tready low meanwhile; cfg writes are taken at any time. Items are worked
// one at a time by a sequencer over a link RAM and a count RAM, each with one
// registered read port. After accept the dispatch state decides: unused action
// and out of memory go straight to the done state; alloc from the caller's own
// list reads the link and then finishes the pop; free and inc/dec/get ref read
// the count and then update it; alloc that steals does one link read per page
// walked; free_total adds one list length per cycle; init clears one page per
// cycle and pushes those from first_free_page up. A finished result waits for
// the output register to drain. The next input can be taken in the cycle after
// the result is loaded into the output register.
// A finished result sits in the output register; the next input is taken
// while it waits, and the following result waits until it drains.
// Status codes: 0 ok, 1 out of memory, 2 bad page, 3 still referenced,
// 4 negative count reset. Steal takes max(1, len/2) pages from the lowest
// numbered non-empty list of another CPU.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // s_tdata: [2:0] action, [5:3] cpu, [15:6] page
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [pfa_pkg::IN_TW-1:0]  s_tdata,
  // m_tdata: [9:0] granted_page, [12:10] status, [20:13] ref_value,
  //          [31:21] free_pages
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [pfa_pkg::OUT_TW-1:0] m_tdata,
  // first_free_page register
  input  wire logic                       cfg_we,
  input  wire logic [pfa_pkg::CFG_W-1:0]  cfg_wdata
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
